FILE: rtl/servo_status_packet_receiver_defines.svh
// Assertion macros used by the servo status packet receiver framer, ssp_frame.
// No dependencies; the using module must provide clk and rst.
`ifndef SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH
`define SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/ssp_pkg.sv
// Types and constants for the servo status packet receiver.
// No dependencies; used by all RTL modules and the testbench.
package ssp_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ARM  = 2'd2;

  // Result kinds.
  localparam logic RK_PARAM  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // Status codes of an end-of-packet result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_BAD_LEN  = 2'd3;

  // Header byte positions and limits.
  localparam logic [7:0]  POS_ID        = 8'd2;
  localparam logic [7:0]  POS_LENGTH    = 8'd3;
  localparam logic [7:0]  MIN_LENGTH    = 8'd2;
  localparam logic [15:0] TICKS_MAX     = 16'hffff;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] status;
    logic [7:0] device_id;
    logic [7:0] device_error;
    logic [7:0] param_index;
    logic [7:0] param_value;
  } ssp_result_t;

  // One processed item's outcome, passed from the framer to the output stage.
  typedef struct packed {
    logic        step;
    logic        valid;
    ssp_result_t data;
  } ssp_step_t;

endpackage

FILE: rtl/ssp_intf.sv
// Handshake channel interfaces for the servo status packet receiver.
// Depends on ssp_pkg for nothing but shares its field widths.
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink (input valid, input kind, input byte_value, output ready);
endinterface

interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] status;
  logic [7:0] device_id;
  logic [7:0] device_error;
  logic [7:0] param_index;
  logic [7:0] param_value;

  modport source (output valid, output result_kind, output status, output device_id,
                  output device_error, output param_index, output param_value,
                  input ready);
  modport sink (input valid, input result_kind, input status, input device_id,
                input device_error, input param_index, input param_value,
                output ready);
endinterface

FILE: rtl/ssp_frame.sv
// Packet framing state machine: phase, counters, checksum and held header fields.
// Depends on ssp_pkg and the assertion macros header.
`include "servo_status_packet_receiver_defines.svh"

module ssp_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        kind,
  input  logic [7:0]        byte_value,
  input  logic [15:0]       timeout_ticks,
  output ssp_pkg::ssp_step_t outcome
);
  import ssp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  packet_length, packet_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_error, held_error_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [15:0] ticks_inc;
  logic [7:0]  sum_plus;
  logic        last_body_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      packet_length <= '0;
      running_sum   <= '0;
      held_id       <= '0;
      held_error    <= '0;
      idle_ticks    <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      packet_length <= packet_length_next;
      running_sum   <= running_sum_next;
      held_id       <= held_id_next;
      held_error    <= held_error_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  assign ticks_inc      = (idle_ticks == TICKS_MAX) ? idle_ticks : 16'(idle_ticks + 16'd1);
  assign sum_plus       = 8'(running_sum + byte_value);
  assign last_body_byte = ({1'b0, byte_position} + 9'd1) >= {1'b0, packet_length};

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    packet_length_next = packet_length;
    running_sum_next   = running_sum;
    held_id_next       = held_id;
    held_error_next    = held_error;
    idle_ticks_next    = idle_ticks;
    outcome                   = '0;
    outcome.step              = step;
    outcome.data.device_id    = held_id;
    outcome.data.device_error = held_error;

    if (step) begin
      unique case (kind)
        KIND_ARM: begin
          phase_next         = PH_HEADER;
          byte_position_next = '0;
          packet_length_next = '0;
          running_sum_next   = '0;
          held_id_next       = '0;
          held_error_next    = '0;
          idle_ticks_next    = '0;
        end
        KIND_BYTE: begin
          if (phase != PH_IDLE) begin
            idle_ticks_next    = '0;
            byte_position_next = 8'(byte_position + 8'd1);
            if (phase == PH_HEADER) begin
              // Sync bytes only advance the position.
              if (byte_position == POS_ID) begin
                held_id_next     = byte_value;
                running_sum_next = sum_plus;
              end else if (byte_position == POS_LENGTH) begin
                packet_length_next = byte_value;
                running_sum_next   = sum_plus;
                byte_position_next = '0;
                if (byte_value < MIN_LENGTH) begin
                  phase_next                = PH_IDLE;
                  outcome.valid             = 1'b1;
                  outcome.data.result_kind  = RK_STATUS;
                  outcome.data.status       = ST_BAD_LEN;
                end else begin
                  phase_next = PH_BODY;
                end
              end
            end else if (last_body_byte) begin
              phase_next               = PH_IDLE;
              outcome.valid            = 1'b1;
              outcome.data.result_kind = RK_STATUS;
              outcome.data.status      = (~running_sum == byte_value) ? ST_OK : ST_CHECKSUM;
            end else begin
              running_sum_next = sum_plus;
              if (byte_position == 8'd0) begin
                held_error_next = byte_value;
              end else begin
                outcome.valid             = 1'b1;
                outcome.data.result_kind  = RK_PARAM;
                outcome.data.param_index  = 8'(byte_position - 8'd1);
                outcome.data.param_value  = byte_value;
              end
            end
          end
        end
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            // A zero timeout needs no special case: the count is at least one here.
            if (ticks_inc >= timeout_ticks) begin
              phase_next               = PH_IDLE;
              idle_ticks_next          = '0;
              outcome.valid            = 1'b1;
              outcome.data.result_kind = RK_STATUS;
              outcome.data.status      = ST_TIMEOUT;
            end else begin
              idle_ticks_next = ticks_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `SSP_ASSERT_IMPL(a_result_needs_step, outcome.valid, step)
  `SSP_ASSERT_NEXT(a_status_ends_packet, outcome.valid && outcome.data.result_kind == RK_STATUS, phase == PH_IDLE)
  `SSP_ASSERT_IMPL(a_body_length_ok, phase == PH_BODY, packet_length >= MIN_LENGTH)
  `SSP_ASSERT_IMPL(a_param_only_in_body, outcome.valid && outcome.data.result_kind == RK_PARAM, phase == PH_BODY && kind == KIND_BYTE)

endmodule

FILE: rtl/ssp_out_stage.sv
// Output register holding one result item until the downstream side takes it.
// Depends on ssp_pkg and the ssp_out_if interface.
module ssp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  ssp_pkg::ssp_step_t outcome,
  output logic               can_load,
  ssp_out_if.source          results
);
  import ssp_pkg::*;

  logic        held_valid;
  ssp_result_t held;

  assign can_load = !held_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (outcome.step && can_load) begin
      held_valid <= outcome.valid;
    end else if (results.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (outcome.step && can_load && outcome.valid) begin
      held <= outcome.data;
    end
  end

  assign results.valid        = held_valid;
  assign results.result_kind  = held.result_kind;
  assign results.status       = held.status;
  assign results.device_id    = held.device_id;
  assign results.device_error = held.device_error;
  assign results.param_index  = held.param_index;
  assign results.param_value  = held.param_value;

endmodule

FILE: rtl/servo_status_packet_receiver.sv
// Top level of the servo status packet receiver: input register, framer, output register.
// Depends on ssp_pkg, ssp_intf.sv, ssp_frame and ssp_out_stage.
//
// Usage: the items channel carries one item per handshake: a received serial byte,
// a timer tick or an arm command (kind 2), which starts a new status packet receive.
// After arming, the block takes two sync bytes, the id and the length, then the error
// byte, the parameter bytes and the checksum. Every parameter byte produces a result
// item on the results channel; the last byte produces an end-of-packet status item
// (ok or checksum error). A length below two ends the receive with a bad length
// status, and timeout_ticks ticks without a byte end it with a timeout status.
// The timeout register is written through cfg_we and cfg_data; the user must write it only
// while the block is idle, since the block itself does not enforce that.
// An accepted item is registered at the input and processed there by the framer once the
// output register can take its outcome; any result it causes is then loaded into the output
// register and is valid on the results channel. Throughput is one item per cycle while the
// results side keeps up; the single framer update per item is what sets that rate.
// Reset (synchronous, active high) returns the framer to idle, clears all held fields
// and the valid flags of both pipeline registers, and loads a timeout of 1000 ticks.
// When the receiver stalls, a finished result waits in the output register, one more
// item waits in the input register, and only then does items.ready drop.
module servo_status_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  ssp_in_if.sink      items,
  ssp_out_if.source   results,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import ssp_pkg::*;

  logic        in_valid;
  logic [1:0]  in_kind;
  logic [7:0]  in_byte;
  logic [15:0] timeout_ticks;
  logic        can_load;
  logic        step;
  ssp_step_t   outcome;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_data;
    end
  end

  // The input register advances whenever the framer may hand its outcome downstream.
  assign step        = in_valid && can_load;
  assign items.ready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_kind <= items.kind;
      in_byte <= items.byte_value;
    end
  end

  ssp_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .kind          (in_kind),
    .byte_value    (in_byte),
    .timeout_ticks (timeout_ticks),
    .outcome       (outcome)
  );

  ssp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .outcome  (outcome),
    .can_load (can_load),
    .results  (results)
  );

endmodule

FILE: bench/servo_status_packet_receiver_tb.sv
// Self-checking testbench for servo_status_packet_receiver: directed and random items
// are checked against a behavioral mirror of the status packet framer.
// Depends on ssp_pkg, the ssp_in_if / ssp_out_if interfaces and the receiver RTL.
module servo_status_packet_receiver_tb;
  import ssp_pkg::*;

  // The item kind that the block must ignore without touching its state.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Only this many failures are printed in full; the rest are just counted.
  localparam int unsigned REPORT_LIMIT = 10;
  // Extra cycles waited so the input and output registers can empty after the queues do.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Packets that are cut short are followed by enough ticks to time out, but only
  // when the timeout is small enough to be reached cheaply.
  localparam int unsigned CHEAP_TIMEOUT = 24;
  // Marks a packet that is sent in full.
  localparam int unsigned WHOLE_PACKET = 1000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } bus_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;

  ssp_in_if  items_bus();
  ssp_out_if results_bus();

  servo_status_packet_receiver u_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_bus),
    .results  (results_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Items waiting to be driven, and results the mirror says the block owes us.
  bus_item_t   pending_items[$];
  ssp_result_t expected_results[$];

  // Mirror of the framer state and of the timeout register.
  phase_t      rx_phase;
  logic [7:0]  rx_pos;
  logic [7:0]  rx_len;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_id;
  logic [7:0]  rx_err;
  logic [15:0] rx_ticks;
  logic [15:0] rx_timeout;

  // Stimulus and bookkeeping.
  bit          idling_on;
  bit          item_taken;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned spare_ticks;
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned param_results;
  int unsigned status_count[4];
  int unsigned fail_count;
  bus_item_t   next_item;
  ssp_result_t got_result;
  ssp_result_t want_result;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results; the limit lies several times
  // above the length of the slowest correct run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void expect_status(logic [1:0] st);
    expected_results.push_back('{result_kind: RK_STATUS, status: st, device_id: rx_id,
                                 device_error: rx_err, param_index: 8'd0,
                                 param_value: 8'd0});
  endfunction

  // Advances the framer mirror by one accepted item and queues the result it causes.
  function automatic void advance_framer(logic [1:0] kind, logic [7:0] value);
    logic [7:0] slot;
    if (kind == KIND_ARM) begin
      // Arming always starts over, even in the middle of a packet, with no result.
      rx_phase = PH_HEADER;
      rx_pos   = '0;
      rx_len   = '0;
      rx_sum   = '0;
      rx_id    = '0;
      rx_err   = '0;
      rx_ticks = '0;
      return;
    end
    if (kind == KIND_UNUSED || rx_phase == PH_IDLE) begin
      return;
    end
    if (kind == KIND_TICK) begin
      if (rx_ticks != TICKS_MAX) begin
        rx_ticks++;
      end
      // A timeout of zero fires on the first tick, the same as a timeout of one.
      if (rx_ticks >= rx_timeout) begin
        rx_phase = PH_IDLE;
        rx_ticks = '0;
        expect_status(ST_TIMEOUT);
      end
      return;
    end
    // Any byte taken while receiving restarts the tick count.
    rx_ticks = '0;
    if (rx_phase == PH_HEADER) begin
      if (rx_pos == POS_LENGTH) begin
        rx_len = value;
        rx_sum += value;
        rx_pos = '0;
        if (value < MIN_LENGTH) begin
          rx_phase = PH_IDLE;
          expect_status(ST_BAD_LEN);
        end else begin
          rx_phase = PH_BODY;
        end
      end else begin
        // The two sync bytes are counted but never checked.
        if (rx_pos == POS_ID) begin
          rx_id = value;
          rx_sum += value;
        end
        rx_pos++;
      end
    end else begin
      slot = rx_pos;
      rx_pos++;
      if ({1'b0, slot} + 9'd1 >= {1'b0, rx_len}) begin
        rx_phase = PH_IDLE;
        expect_status((value == ~rx_sum) ? ST_OK : ST_CHECKSUM);
      end else begin
        rx_sum += value;
        if (slot == 8'd0) begin
          rx_err = value;
        end else begin
          expected_results.push_back('{result_kind: RK_PARAM, status: ST_OK,
                                       device_id: rx_id, device_error: rx_err,
                                       param_index: slot - 8'd1, param_value: value});
        end
      end
    end
  endfunction

  function automatic void push_item(logic [1:0] kind, logic [7:0] value);
    pending_items.push_back('{kind: kind, value: value});
    items_queued++;
  endfunction

  // Queues an arm and a packet of the given length. Only the first keep bytes are
  // sent, so a small keep leaves the receive hanging. Ticks short of the timeout
  // are sprinkled between bytes.
  function automatic void queue_packet(logic [7:0] len, bit good_sum, int unsigned keep);
    logic [7:0]  sum;
    logic [7:0]  id;
    logic [7:0]  b;
    int unsigned total;
    sum = '0;
    id = 8'($urandom);
    total = (len < MIN_LENGTH) ? 4 : 4 + len;
    push_item(KIND_ARM, 8'($urandom));
    for (int unsigned n = 0; n < total && n < keep; n++) begin
      if (n < 2) begin
        b = ($urandom_range(0, 1) == 0) ? 8'hff : 8'($urandom);
      end else if (n == 2) begin
        b = id;
      end else if (n == 3) begin
        b = len;
      end else if (n == total - 1) begin
        b = good_sum ? ~sum : ~sum ^ 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom);
      end
      if (n >= 2) begin
        sum += b;
      end
      push_item(KIND_BYTE, b);
      if (spare_ticks != 0 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, spare_ticks)) push_item(KIND_TICK, 8'($urandom));
      end
    end
  endfunction

  // Blocks until every queued item is in and every owed result is out, then lets
  // the pipeline settle, since the last items may have caused no result at all.
  // The check is repeated after settling, because the driver may hand out the last
  // item on the very edge at which the queue was first seen empty.
  task automatic wait_drained();
    do begin
      while (pending_items.size() != 0 || items_bus.valid || expected_results.size() != 0)
      begin
        @(negedge clk);
      end
      repeat (SETTLE_CYCLES) @(negedge clk);
    end while (pending_items.size() != 0 || items_bus.valid ||
               expected_results.size() != 0);
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    rx_timeout = ticks;
    spare_ticks = (ticks <= 16'd1) ? 0 : ((ticks > 16'd4) ? 3 : ticks - 1);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase at a fixed timeout. Most of the traffic is well-formed
  // packets, mostly short; the rest is cut-off packets, short lengths and noise.
  task automatic random_phase(logic [15:0] ticks, int unsigned budget, bit with_longest);
    int unsigned stop;
    int unsigned pick;
    logic [7:0]  len;
    write_timeout(ticks);
    stop = items_queued + budget;
    if (with_longest) begin
      queue_packet(8'd255, 1'b1, WHOLE_PACKET);
    end
    while (items_queued < stop) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(13, 255))
                                         : 8'($urandom_range(2, 12));
      if (pick < 70) begin
        queue_packet(len, $urandom_range(0, 3) != 0, WHOLE_PACKET);
      end else if (pick < 80) begin
        // Stops mid-packet; either ticks run it out or the next arm drops it.
        queue_packet(len, 1'b1, $urandom_range(1, 3 + len));
        if (ticks <= CHEAP_TIMEOUT) begin
          repeat ((ticks == 16'd0) ? 1 : ticks) push_item(KIND_TICK, 8'($urandom));
        end
      end else if (pick < 85) begin
        queue_packet(8'($urandom_range(0, 1)), 1'b1, WHOLE_PACKET);
      end else begin
        repeat ($urandom_range(1, 4)) push_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  // Item driver: a new item goes out on the falling edge after the previous one was
  // taken. Idle bursts are inserted at random while idling is on.
  always @(negedge clk) begin
    if (rst) begin
      items_bus.valid <= 1'b0;
    end else if (!items_bus.valid || item_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        items_bus.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        items_bus.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 11);
        items_bus.valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        items_bus.valid      <= 1'b1;
        items_bus.kind       <= next_item.kind;
        items_bus.byte_value <= next_item.value;
      end
    end
  end

  // Result receiver: stalls in random bursts while idling is on.
  always @(negedge clk) begin
    if (recv_stall != 0) begin
      recv_stall--;
      results_bus.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 11);
      results_bus.ready <= 1'b0;
    end else begin
      results_bus.ready <= 1'b1;
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. A result is checked
  // before the item of the same edge is fed to the mirror; the block's latency
  // keeps that item's result from showing up on the same edge anyway.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= items_bus.valid && items_bus.ready;
      if (results_bus.valid && results_bus.ready) begin
        got_result = '{result_kind: results_bus.result_kind, status: results_bus.status,
                       device_id: results_bus.device_id,
                       device_error: results_bus.device_error,
                       param_index: results_bus.param_index,
                       param_value: results_bus.param_value};
        results_seen++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result %0d arrived with none owed: %p",
                                   results_seen, got_result));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.result_kind !== want_result.result_kind ||
              got_result.status !== want_result.status ||
              got_result.device_id !== want_result.device_id ||
              got_result.device_error !== want_result.device_error ||
              got_result.param_index !== want_result.param_index ||
              got_result.param_value !== want_result.param_value) begin
            report_failure($sformatf("result %0d: expected %p, got %p",
                                     results_seen, want_result, got_result));
          end else if (want_result.result_kind == RK_STATUS) begin
            status_count[want_result.status]++;
          end else begin
            param_results++;
          end
        end
      end
      if (items_bus.valid && items_bus.ready) begin
        items_taken++;
        advance_framer(items_bus.kind, items_bus.byte_value);
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    items_bus.valid      = 1'b0;
    items_bus.kind       = KIND_BYTE;
    items_bus.byte_value = '0;
    results_bus.ready    = 1'b0;
    idling_on            = 1'b1;
    send_gap             = 0;
    recv_stall           = 0;
    spare_ticks          = 0;
    items_queued         = 0;
    items_taken          = 0;
    results_seen         = 0;
    param_results        = 0;
    fail_count           = 0;
    status_count         = '{default: 0};
    rx_phase             = PH_IDLE;
    rx_pos               = '0;
    rx_len               = '0;
    rx_sum               = '0;
    rx_id                = '0;
    rx_err               = '0;
    rx_ticks             = '0;
    rx_timeout           = TIMEOUT_RESET;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part at a timeout of three ticks. Bytes and ticks while idle are
    // dropped, and both short lengths end the receive at once.
    write_timeout(16'd3);
    push_item(KIND_TICK, 8'h00);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_ARM, 8'h00);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_BYTE, 8'hfe);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_ARM, 8'hff);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_BYTE, 8'h01);
    // A one-parameter packet with a good checksum; the unused kind and two ticks
    // inside it must change nothing.
    push_item(KIND_ARM, 8'h00);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_BYTE, 8'h01);
    push_item(KIND_BYTE, 8'h03);
    push_item(KIND_BYTE, 8'hff);
    push_item(KIND_UNUSED, 8'hff);
    push_item(KIND_BYTE, 8'h80);
    push_item(KIND_TICK, 8'hff);
    push_item(KIND_TICK, 8'h00);
    push_item(KIND_BYTE, 8'h7c);
    // Re-arm in the middle of a header, then let the timeout run out.
    push_item(KIND_ARM, 8'h00);
    push_item(KIND_BYTE, 8'h55);
    push_item(KIND_ARM, 8'h00);
    push_item(KIND_TICK, 8'h00);
    push_item(KIND_TICK, 8'h00);
    push_item(KIND_TICK, 8'h00);

    // Random phases over the timeout extremes and a few ordinary values. The last
    // phase runs with neither side idling.
    random_phase(16'd1, 300, 1'b0);
    random_phase(16'd0, 250, 1'b0);
    random_phase(16'hffff, 350, 1'b1);
    random_phase(16'($urandom_range(2, 8)), 350, 1'b0);
    wait_drained();
    idling_on = 1'b0;
    random_phase(TIMEOUT_RESET, 300, 1'b0);
    wait_drained();

    $display("Took %0d items over six timeout settings; checked %0d results, %0d of them",
             items_taken, results_seen, param_results);
    $display("parameter bytes; ok %0d, checksum %0d, timeout %0d, bad length %0d; %0d failed",
             status_count[ST_OK], status_count[ST_CHECKSUM], status_count[ST_TIMEOUT],
             status_count[ST_BAD_LEN], fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
